// ===== hw/rtl/htbd_pkg.sv =====
`timescale 1ns / 1ps

package htbd_pkg;

   localparam int TableDepth = 256;
   localparam int AddrWidth  = 8;
   localparam int CountWidth = 9;
   localparam int MaxCodeLen = 16;
   localparam int ByteBits   = 8;

   typedef struct packed {
      logic        func;
      logic        restart;
      logic [7:0]  symbol;
      logic [4:0]  code_length;
      logic [15:0] code_value;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [2:0]  pad_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol_out;
      logic       code_error;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic        is_data;
      logic        restart;
      logic [7:0]  symbol;
      logic [4:0]  code_length;
      logic [15:0] code_value;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [3:0]  nbits;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  symbol;
      logic [4:0]  length;
      logic [15:0] code;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_READ,
      ST_CMP,
      ST_PUSH,
      ST_NEXT,
      ST_FIN
   } state_type;

endpackage

// ===== hw/rtl/htbd_front.sv =====
`timescale 1ns / 1ps

module htbd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  htbd_pkg::req_type req_data,
   output logic              cmd_valid,
   output htbd_pkg::cmd_type cmd_head,
   input  logic              cmd_pop
);

   htbd_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   htbd_pkg::cmd_type cmd_new;
   logic [15:0]       mask;
   logic              push;

   always_comb begin
      mask = (req_data.code_length >= 5'd16) ? 16'hFFFF
           : 16'((17'd1 << req_data.code_length) - 17'd1);
      cmd_new.is_data     = req_data.func;
      cmd_new.restart     = req_data.restart;
      cmd_new.symbol      = req_data.symbol;
      cmd_new.code_length = req_data.code_length;
      cmd_new.code_value  = req_data.code_value & mask;
      cmd_new.data_byte   = req_data.data_byte;
      cmd_new.last_byte   = req_data.last_byte;
      cmd_new.nbits       = req_data.last_byte ? 4'(4'd8 - {1'b0, req_data.pad_bits}) : 4'd8;
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = 2'(fill_ff + {1'b0, push} - {1'b0, cmd_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== hw/rtl/htbd_back.sv =====
`timescale 1ns / 1ps

module htbd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  htbd_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output htbd_pkg::rsp_type rsp_data
);

   htbd_pkg::entry_type mem [htbd_pkg::TableDepth];
   htbd_pkg::entry_type rd_entry_ff;
   htbd_pkg::state_type state_ff, state_in;
   logic [htbd_pkg::CountWidth-1:0] idx_ff, idx_in;
   logic [htbd_pkg::CountWidth-1:0] count_ff, count_in;
   logic [15:0]         pbits_ff, pbits_in;
   logic [4:0]          plen_ff, plen_in;
   logic [3:0]          bitn_ff, bitn_in;
   htbd_pkg::rsp_type   res_ff, res_in;
   htbd_pkg::rsp_type   pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   htbd_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                out_free;
   logic                wr_en;
   logic [htbd_pkg::AddrWidth-1:0] wr_addr;
   logic [htbd_pkg::AddrWidth-1:0] rd_addr;
   htbd_pkg::entry_type wr_data;
   logic [4:0]          key_len;
   logic [15:0]         key_code;
   logic                match;
   logic                bit_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      key_len  = cmd_head.is_data ? plen_ff : cmd_head.code_length;
      key_code = cmd_head.is_data ? pbits_ff : cmd_head.code_value;
      match    = (rd_entry_ff.length == key_len) && (rd_entry_ff.code == key_code);
      bit_in   = cmd_head.data_byte[3'(3'd7 - bitn_ff[2:0])];
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pbits_in      = pbits_ff;
      plen_in       = plen_ff;
      bitn_in       = bitn_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[htbd_pkg::AddrWidth-1:0];
      wr_data       = '{symbol: cmd_head.symbol, length: cmd_head.code_length,
                        code: cmd_head.code_value};
      rd_addr       = idx_ff[htbd_pkg::AddrWidth-1:0];
      case (state_ff)
         htbd_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_head.is_data) begin
                  bitn_in  = 4'd0;
                  state_in = htbd_pkg::ST_SHIFT;
               end else begin
                  if (cmd_head.restart) begin
                     count_in = '0;
                     pbits_in = '0;
                     plen_in  = '0;
                  end
                  idx_in   = '0;
                  state_in = htbd_pkg::ST_READ;
               end
            end
         end
         htbd_pkg::ST_SHIFT: begin
            pbits_in = {pbits_ff[14:0], bit_in};
            plen_in  = 5'(plen_ff + 5'd1);
            idx_in   = '0;
            state_in = htbd_pkg::ST_READ;
         end
         htbd_pkg::ST_READ: begin
            if (idx_ff == count_ff) begin
               if (!cmd_head.is_data) begin
                  if (count_ff < htbd_pkg::CountWidth'(htbd_pkg::TableDepth)) begin
                     wr_en    = 1'b1;
                     count_in = htbd_pkg::CountWidth'(count_ff + 1'b1);
                  end
                  state_in = htbd_pkg::ST_FIN;
               end else if (plen_ff >= 5'(htbd_pkg::MaxCodeLen)) begin
                  res_in   = '{symbol_out: 8'd0, code_error: 1'b1, last: 1'b0};
                  pbits_in = '0;
                  plen_in  = '0;
                  state_in = htbd_pkg::ST_PUSH;
               end else begin
                  state_in = htbd_pkg::ST_NEXT;
               end
            end else begin
               state_in = htbd_pkg::ST_CMP;
            end
         end
         htbd_pkg::ST_CMP: begin
            if (match) begin
               if (!cmd_head.is_data) begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[htbd_pkg::AddrWidth-1:0];
                  state_in = htbd_pkg::ST_FIN;
               end else begin
                  res_in   = '{symbol_out: rd_entry_ff.symbol, code_error: 1'b0, last: 1'b0};
                  pbits_in = '0;
                  plen_in  = '0;
                  state_in = htbd_pkg::ST_PUSH;
               end
            end else begin
               idx_in   = htbd_pkg::CountWidth'(idx_ff + 1'b1);
               state_in = htbd_pkg::ST_READ;
            end
         end
         htbd_pkg::ST_PUSH: begin
            if (!pend_valid_ff) begin
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
               state_in      = htbd_pkg::ST_NEXT;
            end else if (out_free) begin
               rsp_data_in   = pend_ff;
               rsp_valid_in  = 1'b1;
               pend_in       = res_ff;
               state_in      = htbd_pkg::ST_NEXT;
            end
         end
         htbd_pkg::ST_NEXT: begin
            bitn_in = 4'(bitn_ff + 4'd1);
            if (4'(bitn_ff + 4'd1) == cmd_head.nbits) begin
               if (cmd_head.last_byte) begin
                  pbits_in = '0;
                  plen_in  = '0;
               end
               state_in = htbd_pkg::ST_FIN;
            end else begin
               state_in = htbd_pkg::ST_SHIFT;
            end
         end
         htbd_pkg::ST_FIN: begin
            if (!pend_valid_ff) begin
               cmd_pop  = 1'b1;
               state_in = htbd_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_data_in      = pend_ff;
               rsp_data_in.last = 1'b1;
               rsp_valid_in     = 1'b1;
               pend_valid_in    = 1'b0;
               cmd_pop          = 1'b1;
               state_in         = htbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htbd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htbd_pkg::ST_IDLE;
         count_ff      <= '0;
         pbits_ff      <= '0;
         plen_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pbits_ff      <= pbits_in;
         plen_ff       <= plen_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      bitn_ff     <= bitn_in;
      res_ff      <= res_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_entry_ff <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/huffman_table_bit_decoder.sv =====
`timescale 1ns / 1ps
// Huffman table bit decoder.
// The req_ channel carries one transaction per table entry or data byte; the
// rsp_ channel returns decoded symbols or error results, last marking the
// final result of one data byte. A table entry returns nothing.
// A two-entry queue takes transactions while the decoder works, so req_stall
// rises only when the queue is full.
// Table entry: the duplicate search reads the N entries in use one at a time,
// with a read state and a compare state per entry.
// Data byte: one scan of the table per code bit, up to eight bits per byte.
// Results pass through one output register and one holding register; while
// rsp_stall is high the decoder waits and no result is lost or repeated.
// Reset empties the queue, the table (entry count to zero) and the partial
// code; table memory contents need no clearing.
module huffman_table_bit_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  htbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output htbd_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   htbd_pkg::cmd_type cmd_head;

   htbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop)
   );

   htbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
